[hw/rtl/ahbr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader package
// Shared constants, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package ahbr_pkg;

   localparam int STORE_BYTES_DEF = 4096;
   localparam int MAX_FIELD_BITS  = 32;

   localparam int KIND_W    = 4;
   localparam int INDEX_W   = 12;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 6;
   localparam int RANGE_W   = 32;
   localparam int SKIP_W    = 16;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 16;
   localparam int OFFSET_W  = 12;
   localparam int SIZE_W    = 13;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_PAYLOAD_OFFSET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAYLOAD_SIZE   = 1'd1;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_RESTART = 4'd1;
   localparam logic [KIND_W-1:0] KIND_FBITS   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SU      = 4'd3;
   localparam logic [KIND_W-1:0] KIND_UVLC    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_NS      = 4'd5;
   localparam logic [KIND_W-1:0] KIND_SKIP    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ALIGN   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_TRAIL   = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ARG  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_DATA = 2'd3;

   // Bit count source for a field read.
   localparam logic [1:0] CNT_FIELD = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_ZEROS = 2'd2;
   localparam logic [1:0] CNT_NSW   = 2'd3;

   // Final value selection.
   localparam logic [2:0] VS_ZERO  = 3'd0;
   localparam logic [2:0] VS_ACC   = 3'd1;
   localparam logic [2:0] VS_SU    = 3'd2;
   localparam logic [2:0] VS_UVLC  = 3'd3;
   localparam logic [2:0] VS_ONES  = 3'd4;
   localparam logic [2:0] VS_NSADJ = 3'd5;

   typedef struct packed {
      logic       capture;
      logic       load_we;
      logic       restart;
      logic       skip;
      logic       chk;
      logic [1:0] count_sel;
      logic       keep_acc;
      logic       fetch;
      logic       shift;
      logic       zeros_clr;
      logic       zeros_inc;
      logic       ns_init;
      logic       ns_step;
      logic       ns_min;
      logic       set_bad;
      logic       finish;
      logic [2:0] vsel;
   } ahbr_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              sticky_nz;
      logic              chk_fail;
      logic              count_zero;
      logic              oob;
      logic              rem_last;
      logic              bit_val;
      logic              aligned;
      logic              at_end;
      logic              ns_small;
      logic              ns_tmp_zero;
      logic              less_min;
      logic              zeros_max;
      logic              out_busy;
   } ahbr_stat_type;

endpackage

[hw/rtl/ahbr_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ahbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/ahbr_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader datapath
// Item capture, configuration, bit cursor, error state, payload store,
// field accumulator and the result register.
// ---------------------------------------------------------------------------
module ahbr_datapath #(
   parameter int STORE_BYTES = ahbr_pkg::STORE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ahbr_pkg::ahbr_cmd_type              cmd,
   output ahbr_pkg::ahbr_stat_type             stat,
   input  logic [ahbr_pkg::KIND_W-1:0]         req_tuser,
   input  logic [ahbr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ahbr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ahbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ahbr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ahbr_pkg::*;

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int FULL_W = 17;

   logic [KIND_W-1:0]   kind_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [BYTE_W-1:0]   bval_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [RANGE_W-1:0]  rn_ff;
   logic [SKIP_W-1:0]   skip_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [POS_W-1:0]    cursor_ff, cursor_in;
   logic [STATUS_W-1:0] sticky_ff, sticky_in;
   logic                bad_ff;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  zeros_ff;
   logic [RANGE_W-1:0]  tmp_ff;
   logic [COUNT_W-1:0]  w_ff;
   logic [VALUE_W-1:0]  min_ff;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [POS_W-1:0]    rsp_pos_ff;

   logic [COUNT_W-1:0]  count;
   logic [POS_W-1:0]    limit;
   logic [FULL_W-1:0]   need;
   logic [FULL_W-1:0]   need_skip;
   logic                bound_fail;
   logic                arg_fail;
   logic [FULL_W-1:0]   full_addr;
   logic                oob;
   logic [BYTE_W-1:0]   rd_data;
   logic                rd_bit;
   logic                wr_ok;
   logic [VALUE_W-1:0]  sign;
   logic [VALUE_W-1:0]  sel_value;
   logic [STATUS_W-1:0] fin_status;

   always_comb begin
      unique case (cmd.count_sel)
         CNT_FIELD: count = cnt_ff;
         CNT_ONE:   count = COUNT_W'(1);
         CNT_ZEROS: count = zeros_ff;
         default:   count = w_ff - COUNT_W'(1);
      endcase
   end

   assign limit      = {size_ff, 3'b000};
   assign need       = FULL_W'(cursor_ff) + FULL_W'(count);
   assign need_skip  = FULL_W'(cursor_ff) + FULL_W'(skip_ff);
   assign bound_fail = need > FULL_W'(limit);
   assign arg_fail   = count > COUNT_W'(MAX_FIELD_BITS);
   assign full_addr  = FULL_W'(offset_ff) + FULL_W'(cursor_ff[POS_W-1:3]);
   assign oob        = full_addr >= FULL_W'(STORE_BYTES);
   assign rd_bit     = rd_data[3'd7 - cursor_ff[2:0]];
   assign wr_ok      = FULL_W'(idx_ff) < FULL_W'(STORE_BYTES);

   ahbr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_we && wr_ok),
      .wr_addr (ADDR_W'(FULL_W'(idx_ff))),
      .wr_data (bval_ff),
      .rd_addr (full_addr[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Cursor, sticky error and accumulator updates.
   always_comb begin
      cursor_in = cursor_ff;
      sticky_in = sticky_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      if (cmd.restart) begin
         cursor_in = '0;
         sticky_in = ST_OK;
      end
      if (cmd.skip && sticky_ff == ST_OK) begin
         if (need_skip > FULL_W'(limit)) begin
            sticky_in = ST_TRUNC;
         end else begin
            cursor_in = need_skip[POS_W-1:0];
         end
      end
      if (cmd.chk && sticky_ff == ST_OK) begin
         if (arg_fail) begin
            sticky_in = ST_BAD_ARG;
         end else if (bound_fail) begin
            sticky_in = ST_TRUNC;
         end else begin
            rem_in = count;
            if (!cmd.keep_acc) begin
               acc_in = '0;
            end
         end
      end
      if (cmd.fetch && oob) begin
         cursor_in = cursor_ff + POS_W'(1);
         sticky_in = ST_TRUNC;
      end
      if (cmd.shift) begin
         acc_in    = {acc_ff[VALUE_W-2:0], rd_bit};
         cursor_in = cursor_ff + POS_W'(1);
         rem_in    = rem_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      sign = VALUE_W'(1) << (cnt_ff[4:0] - 5'd1);
      unique case (cmd.vsel)
         VS_ACC:   sel_value = acc_ff;
         VS_SU: begin
            if (cnt_ff != '0 && cnt_ff <= COUNT_W'(MAX_FIELD_BITS)) begin
               sel_value = (acc_ff ^ sign) - sign;
            end else begin
               sel_value = acc_ff;
            end
         end
         VS_UVLC:  sel_value = ((VALUE_W'(1) << zeros_ff[4:0]) - VALUE_W'(1)) + acc_ff;
         VS_ONES:  sel_value = '1;
         VS_NSADJ: sel_value = acc_ff - min_ff;
         default:  sel_value = '0;
      endcase
      if (sticky_ff != ST_OK) begin
         fin_status = sticky_ff;
      end else if (bad_ff) begin
         fin_status = ST_BAD_DATA;
      end else begin
         fin_status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         sticky_ff    <= ST_OK;
         offset_ff    <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         sticky_ff <= sticky_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_PAYLOAD_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
               default:            size_ff   <= csr_wdata[SIZE_W-1:0];
            endcase
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         idx_ff  <= req_tdata[11:0];
         bval_ff <= req_tdata[19:12];
         cnt_ff  <= req_tdata[25:20];
         rn_ff   <= req_tdata[57:26];
         skip_ff <= req_tdata[73:58];
         bad_ff  <= 1'b0;
      end else if (cmd.set_bad) begin
         bad_ff <= 1'b1;
      end
      if (cmd.zeros_clr) begin
         zeros_ff <= '0;
      end else if (cmd.zeros_inc) begin
         zeros_ff <= zeros_ff + COUNT_W'(1);
      end
      if (cmd.ns_init) begin
         tmp_ff <= rn_ff - RANGE_W'(1);
         w_ff   <= '0;
      end else if (cmd.ns_step) begin
         tmp_ff <= tmp_ff >> 1;
         w_ff   <= w_ff + COUNT_W'(1);
      end
      if (cmd.ns_min) begin
         min_ff <= VALUE_W'((33'd1 << w_ff) - 33'(rn_ff));
      end
      if (cmd.finish) begin
         rsp_status_ff <= fin_status;
         rsp_pos_ff    <= cursor_ff;
         if (fin_status != ST_OK || kind_ff >= KIND_SKIP) begin
            rsp_value_ff <= '0;
         end else begin
            rsp_value_ff <= sel_value;
         end
      end
   end

   assign stat.kind        = kind_ff;
   assign stat.sticky_nz   = sticky_ff != ST_OK;
   assign stat.chk_fail    = sticky_ff != ST_OK || arg_fail || bound_fail;
   assign stat.count_zero  = count == '0;
   assign stat.oob         = oob;
   assign stat.rem_last    = rem_ff == COUNT_W'(1);
   assign stat.bit_val     = acc_ff[0];
   assign stat.aligned     = cursor_ff[2:0] == 3'd0;
   assign stat.at_end      = cursor_ff >= limit;
   assign stat.ns_small    = rn_ff <= RANGE_W'(1);
   assign stat.ns_tmp_zero = tmp_ff == '0;
   assign stat.less_min    = acc_ff < min_ff;
   assign stat.zeros_max   = zeros_ff == COUNT_W'(MAX_FIELD_BITS - 1);
   assign stat.out_busy    = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_pos_ff, rsp_status_ff, rsp_value_ff};
endmodule

[hw/rtl/ahbr_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader controller
// Sequences each command through checks, store fetches and bit shifts.
// ---------------------------------------------------------------------------
module ahbr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ahbr_pkg::ahbr_stat_type stat,
   output ahbr_pkg::ahbr_cmd_type  cmd
);
   import ahbr_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_NSW    = 4'd2;
   localparam logic [3:0] S_GCHK   = 4'd3;
   localparam logic [3:0] S_GFETCH = 4'd4;
   localparam logic [3:0] S_GBIT   = 4'd5;
   localparam logic [3:0] S_AFTER  = 4'd6;
   localparam logic [3:0] S_ATEST  = 4'd7;
   localparam logic [3:0] S_TTEST  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic [2:0] vsel_ff, vsel_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      phase_in   = phase_ff;
      vsel_in    = vsel_ff;
      req_tready = 1'b0;
      // The count source follows from the command and its phase.
      unique case (stat.kind)
         KIND_FBITS, KIND_SU: cmd.count_sel = CNT_FIELD;
         KIND_UVLC:           cmd.count_sel = phase_ff ? CNT_ZEROS : CNT_ONE;
         KIND_NS:             cmd.count_sel = phase_ff ? CNT_ONE : CNT_NSW;
         default:             cmd.count_sel = CNT_ONE;
      endcase
      cmd.keep_acc = (stat.kind == KIND_NS) && phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               phase_in    = 1'b0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            vsel_in = VS_ZERO;
            unique case (stat.kind)
               KIND_LOAD: begin
                  cmd.load_we = 1'b1;
                  state_in    = S_DONE;
               end
               KIND_RESTART: begin
                  cmd.restart = 1'b1;
                  state_in    = S_DONE;
               end
               KIND_FBITS: begin
                  vsel_in  = VS_ACC;
                  state_in = S_GCHK;
               end
               KIND_SU: begin
                  vsel_in  = VS_SU;
                  state_in = S_GCHK;
               end
               KIND_UVLC: begin
                  cmd.zeros_clr = 1'b1;
                  vsel_in       = VS_UVLC;
                  state_in      = S_GCHK;
               end
               KIND_NS: begin
                  if (stat.ns_small) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.ns_init = 1'b1;
                     vsel_in     = VS_ACC;
                     state_in    = S_NSW;
                  end
               end
               KIND_SKIP: begin
                  cmd.skip = 1'b1;
                  state_in = S_DONE;
               end
               KIND_ALIGN: state_in = S_ATEST;
               KIND_TRAIL: state_in = S_GCHK;
               default:    state_in = S_DONE;
            endcase
         end
         S_NSW: begin
            // Width of the ns field is the bit length of n - 1.
            if (stat.ns_tmp_zero) begin
               cmd.ns_min = 1'b1;
               state_in   = S_GCHK;
            end else begin
               cmd.ns_step = 1'b1;
            end
         end
         S_GCHK: begin
            cmd.chk = 1'b1;
            if (stat.chk_fail || stat.count_zero) begin
               state_in = S_AFTER;
            end else begin
               state_in = S_GFETCH;
            end
         end
         S_GFETCH: begin
            cmd.fetch = 1'b1;
            state_in  = stat.oob ? S_AFTER : S_GBIT;
         end
         S_GBIT: begin
            cmd.shift = 1'b1;
            state_in  = stat.rem_last ? S_AFTER : S_GFETCH;
         end
         S_AFTER: begin
            state_in = S_DONE;
            unique case (stat.kind)
               KIND_UVLC: begin
                  if (!phase_ff && !stat.sticky_nz) begin
                     if (stat.bit_val) begin
                        phase_in = 1'b1;
                        state_in = S_GCHK;
                     end else if (stat.zeros_max) begin
                        vsel_in = VS_ONES;
                     end else begin
                        cmd.zeros_inc = 1'b1;
                        state_in      = S_GCHK;
                     end
                  end
               end
               KIND_NS: begin
                  if (!phase_ff && !stat.sticky_nz && !stat.less_min) begin
                     phase_in = 1'b1;
                     vsel_in  = VS_NSADJ;
                     state_in = S_GCHK;
                  end
               end
               KIND_ALIGN: begin
                  if (!stat.sticky_nz) begin
                     if (stat.bit_val) begin
                        cmd.set_bad = 1'b1;
                     end else begin
                        state_in = S_ATEST;
                     end
                  end
               end
               KIND_TRAIL: begin
                  if (!phase_ff) begin
                     if (stat.sticky_nz || !stat.bit_val) begin
                        cmd.set_bad = 1'b1;
                     end else begin
                        phase_in = 1'b1;
                        state_in = S_TTEST;
                     end
                  end else if (!stat.sticky_nz && stat.bit_val) begin
                     cmd.set_bad = 1'b1;
                  end else begin
                     state_in = S_TTEST;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_ATEST: begin
            state_in = (stat.aligned || stat.sticky_nz) ? S_DONE : S_GCHK;
         end
         S_TTEST: begin
            state_in = (stat.at_end || stat.sticky_nz) ? S_DONE : S_GCHK;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               cmd.vsel   = vsel_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         vsel_ff  <= VS_ZERO;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         vsel_ff  <= vsel_in;
      end
   end
endmodule

[hw/rtl/av1_header_bit_reader.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader
// MSB-first reader of AV1 header syntax over a loadable payload byte store.
// ---------------------------------------------------------------------------
// The req channel carries one command per transaction: tuser is the kind,
// tdata the operands. Load transactions fill the byte store; the others read
// f(n), su(n), uvlc, ns(n) fields, skip bits, or check alignment and
// trailing bits. Every command yields exactly one rsp transaction with the
// value, a status and the bit cursor after the command.
// Commands run one at a time. Load, restart, skip and unknown kinds go from
// capture through the execute state to the result. A field read checks its
// bounds, then fetches the byte of each bit from the registered read port
// of the byte store and shifts the bit in (one fetch and one shift per bit);
// uvlc reads its prefix bits the same way, stop bit included, ns first finds
// the width w (the bit length of n - 1) and then reads the extra bit when
// needed, and alignment and trailing checks walk the bits one at a time.
// A new command is accepted once the previous result sits in the output
// register, even while the receiver stalls; a following result waits in the
// controller until the output register is taken.
// Synchronous reset clears the cursor, the sticky error, both configuration
// registers and any pending result. The byte store is not cleared.
// ---------------------------------------------------------------------------
module av1_header_bit_reader #(
   parameter int STORE_BYTES = ahbr_pkg::STORE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // kind
   input  logic [ahbr_pkg::KIND_W-1:0]         req_tuser,
   // byte_index, byte_value, bit_count, range_n, skip_bits, zero fill
   input  logic [ahbr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // value, status, cursor position, zero fill
   output logic [ahbr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [ahbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ahbr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ahbr_pkg::*;

   ahbr_cmd_type  cmd;
   ahbr_stat_type stat;

   ahbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ahbr_datapath #(.STORE_BYTES(STORE_BYTES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );
endmodule

[hw/rtl/ahbr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader checker
// Port-level properties of the reader, bound to the top level.
// ---------------------------------------------------------------------------
module ahbr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ahbr_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ahbr_pkg::*;

   // No result survives a reset.
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Commands are handled one at a time.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command accepted back to back");

   // A failed command never returns a value.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != ST_OK |-> rsp_tdata[31:0] == '0)
      else $error("nonzero value with error status");

   // A stalled result holds.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind av1_header_bit_reader ahbr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/av1_header_bit_reader_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader checker
// Watches the command, result and register ports, decodes every accepted
// command with its own copy of the store, cursor and sticky error, and
// compares each result transaction with the oldest decoded expectation.
// ---------------------------------------------------------------------------
module av1_header_bit_reader_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ahbr_pkg::KIND_W-1:0]     req_tuser,
   input  logic [ahbr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ahbr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [ahbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ahbr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              pending,
   output int                              failures,
   output int                              checked
);
   import ahbr_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    pos;
   } field_result_type;

   localparam int STORE = STORE_BYTES_DEF;

   logic [BYTE_W-1:0]   shadow_store [STORE];
   logic [31:0]         cursor;
   logic [STATUS_W-1:0] sticky;
   logic [31:0]         window_offset;
   logic [31:0]         window_bytes;
   field_result_type    awaited [$];

   function automatic logic [31:0] take_bits(input logic [31:0] cnt);
      logic [31:0] lim;
      logic [31:0] acc;
      logic [31:0] addr;
      logic [31:0] pos;
      lim = window_bytes * 8;
      acc = 0;
      if (sticky != ST_OK) return 0;
      if (cnt > MAX_FIELD_BITS) begin
         sticky = ST_BAD_ARG;
         return 0;
      end
      if (cursor > lim || cnt > lim - cursor) begin
         sticky = ST_TRUNC;
         return 0;
      end
      for (int k = 0; k < cnt; k++) begin
         pos = cursor;
         addr = window_offset + (pos >> 3);
         cursor = pos + 1;
         if (addr >= STORE) begin
            sticky = ST_TRUNC;
            return 0;
         end
         acc = (acc << 1) | 32'(shadow_store[addr][7 - pos[2:0]]);
      end
      return acc;
   endfunction

   function automatic logic [31:0] take_uvlc();
      logic [31:0] zeros;
      logic [31:0] b;
      logic [31:0] tail;
      zeros = 0;
      forever begin
         b = take_bits(1);
         if (sticky != ST_OK) return 0;
         if (b != 0) break;
         zeros++;
         // A prefix of 32 zeros saturates without reading a suffix.
         if (zeros >= 32) return 32'hffff_ffff;
      end
      tail = take_bits(zeros);
      return ((32'd1 << zeros) - 1) + tail;
   endfunction

   function automatic logic [31:0] take_ns(input logic [31:0] n);
      logic [31:0] width;
      logic [63:0] power;
      logic [31:0] minimum;
      logic [31:0] v;
      width = 0;
      power = 1;
      if (n <= 1) return 0;
      while (power < {32'd0, n}) begin
         power = power << 1;
         width++;
      end
      minimum = 32'(power - {32'd0, n});
      v = take_bits(width - 1);
      if (v < minimum) return v;
      v = (v << 1) - minimum;
      return v + take_bits(1);
   endfunction

   function automatic field_result_type decode_item(input logic [KIND_W-1:0] kind,
                                                    input logic [REQ_DATA_W-1:0] d);
      logic [INDEX_W-1:0] idx;
      logic [BYTE_W-1:0]  bval;
      logic [COUNT_W-1:0] cnt;
      logic [RANGE_W-1:0] rn;
      logic [SKIP_W-1:0]  skip;
      logic [31:0]        value;
      logic [31:0]        sign;
      logic [31:0]        lim;
      logic               bad_data;
      field_result_type   r;
      idx = d[11:0];
      bval = d[19:12];
      cnt = d[25:20];
      rn = d[57:26];
      skip = d[73:58];
      value = 0;
      bad_data = 1'b0;
      lim = window_bytes * 8;
      case (kind)
         KIND_LOAD: shadow_store[idx] = bval;
         KIND_RESTART: begin
            cursor = 0;
            sticky = ST_OK;
         end
         KIND_FBITS: value = take_bits(32'(cnt));
         KIND_SU: begin
            value = take_bits(32'(cnt));
            if (cnt >= 1 && cnt <= MAX_FIELD_BITS) begin
               sign = 32'd1 << (cnt - 1);
               value = (value ^ sign) - sign;
            end
         end
         KIND_UVLC: value = take_uvlc();
         KIND_NS: value = take_ns(rn);
         KIND_SKIP: begin
            if (sticky == ST_OK) begin
               if (cursor > lim || 32'(skip) > lim - cursor) sticky = ST_TRUNC;
               else cursor = cursor + 32'(skip);
            end
         end
         KIND_ALIGN: begin
            while (cursor[2:0] != 0 && sticky == ST_OK) begin
               if (take_bits(1) != 0) begin
                  bad_data = 1'b1;
                  break;
               end
            end
         end
         KIND_TRAIL: begin
            if (take_bits(1) != 1) begin
               bad_data = 1'b1;
            end else begin
               while (sticky == ST_OK && cursor < lim) begin
                  if (take_bits(1) != 0) begin
                     bad_data = 1'b1;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      r.status = sticky;
      if (r.status == ST_OK && bad_data) r.status = ST_BAD_DATA;
      if (r.status != ST_OK || kind >= KIND_SKIP) value = 0;
      r.value = value;
      r.pos = cursor[15:0];
      return r;
   endfunction

   initial begin
      failures = 0;
      checked = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      field_result_type want;
      field_result_type got;
      if (reset) begin
         cursor = 0;
         sticky = ST_OK;
         window_offset = 0;
         window_bytes = 0;
         awaited.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_PAYLOAD_OFFSET) window_offset = 32'(csr_wdata[11:0]);
            else if (csr_index == REG_PAYLOAD_SIZE) window_bytes = 32'(csr_wdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[31:0];
            got.status = rsp_tdata[33:32];
            got.pos = rsp_tdata[49:34];
            if (awaited.size() == 0) begin
               $error("result transaction with no command outstanding");
               failures++;
            end else begin
               want = awaited.pop_front();
               checked++;
               if (got.value !== want.value) begin
                  $error("value: expected %h, got %h", want.value, got.value);
                  failures++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  failures++;
               end
               if (got.pos !== want.pos) begin
                  $error("cursor_pos: expected %0d, got %0d", want.pos, got.pos);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) awaited.push_back(decode_item(req_tuser, req_tdata));
      end
      pending = awaited.size();
   end

endmodule

[tb/sv/av1_header_bit_reader_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AV1 header bit reader testbench
// Loads small payload windows, then issues directed and random field reads
// over several offset and size settings with bursty commands and a stalling
// result receiver; the checker module decodes and compares every result.
// ---------------------------------------------------------------------------
module av1_header_bit_reader_tb;
   import ahbr_pkg::*;

   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int PHASES = 30;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [KIND_W-1:0]     req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int  pending;
   int  failures;
   int  checked;
   int  sent;
   int  cycles;
   int  burst_left;
   bit  offering;
   bit  long_hold;
   int  cur_offset;
   int  cur_size;

   av1_header_bit_reader uut (.*);

   av1_header_bit_reader_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL av1_header_bit_reader");
         $finish;
      end
   end

   // Result receiver: its own stall pattern, plus one long hold on request.
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 50;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= (cycles % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
            mode_left--;
            if (mode_left <= 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
         end
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [11:0] idx,
         input logic [7:0] bv, input logic [5:0] cnt, input logic [31:0] rn,
         input logic [15:0] sk);
      return {6'd0, sk, rn, cnt, bv, idx};
   endfunction

   task automatic send(input logic [KIND_W-1:0] k, input logic [REQ_DATA_W-1:0] d);
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= d;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 15);
      end else begin
         burst_left--;
      end
   endtask

   // Byte index and byte value, unused by these kinds, still carry random values.
   task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [5:0] cnt,
                           input logic [31:0] rn, input logic [15:0] sk);
      send(k, pack_req(12'($urandom), 8'($urandom), cnt, rn, sk));
   endtask

   task automatic load_byte(input int idx, input logic [7:0] v);
      send(KIND_LOAD, pack_req(12'(idx), v, 6'($urandom), $urandom, 16'($urandom)));
   endtask

   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Every store byte the window can reach is written before any read.
   task automatic set_window(input int off, input int size);
      int last;
      drain();
      write_reg(REG_PAYLOAD_OFFSET, off);
      write_reg(REG_PAYLOAD_SIZE, size);
      cur_offset = off;
      cur_size = size;
      last = (off + size > STORE_BYTES_DEF) ? STORE_BYTES_DEF : off + size;
      for (int i = off; i < last; i++) begin
         if (i == last - 1 && $urandom_range(0, 2) == 0) load_byte(i, 8'h80);
         else if ($urandom_range(0, 5) == 0) load_byte(i, 8'h00);
         else load_byte(i, 8'($urandom));
      end
      send_cmd(KIND_RESTART, 0, 0, 0);
   endtask

   task automatic random_cmd();
      int pick;
      logic [5:0] cnt;
      logic [31:0] rn;
      logic [15:0] sk;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
         0: cnt = 6'($urandom_range(33, 63));
         1, 2, 3: cnt = 6'($urandom_range(17, 32));
         default: cnt = 6'($urandom_range(0, 16));
      endcase
      case ($urandom_range(0, 9))
         0: rn = $urandom;
         1, 2: rn = $urandom_range(0, 65536);
         default: rn = $urandom_range(0, 20);
      endcase
      sk = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      if (pick < 8) load_byte($urandom_range(0, STORE_BYTES_DEF - 1), 8'($urandom));
      else if (pick < 18) send_cmd(KIND_RESTART, cnt, rn, sk);
      else if (pick < 38) send_cmd(KIND_FBITS, cnt, rn, sk);
      else if (pick < 50) send_cmd(KIND_SU, cnt, rn, sk);
      else if (pick < 62) send_cmd(KIND_UVLC, cnt, rn, sk);
      else if (pick < 74) send_cmd(KIND_NS, cnt, rn, sk);
      else if (pick < 82) send_cmd(KIND_SKIP, cnt, rn, sk);
      else if (pick < 89) send_cmd(KIND_ALIGN, cnt, rn, sk);
      else if (pick < 95) send_cmd(KIND_TRAIL, cnt, rn, sk);
      else send_cmd(KIND_W'(KIND_TRAIL + 1 + $urandom_range(0, 6)), cnt, rn, sk);
   endtask

   initial begin
      int off;
      int size;
      cycles = 0;
      sent = 0;
      burst_left = 10;
      offering = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: long uvlc prefix, field width limits, sticky errors,
      // ns edge ranges, skip limits, alignment, trailing bits, unknown kinds.
      drain();
      write_reg(REG_PAYLOAD_OFFSET, 100);
      write_reg(REG_PAYLOAD_SIZE, 8);
      load_byte(100, 8'h00);
      load_byte(101, 8'h00);
      load_byte(102, 8'h00);
      load_byte(103, 8'h00);
      load_byte(104, 8'hA5);
      load_byte(105, 8'hFF);
      load_byte(106, 8'h5A);
      load_byte(107, 8'h80);
      send_cmd(KIND_UVLC, 0, 0, 0);
      send_cmd(KIND_FBITS, 0, 0, 0);
      send_cmd(KIND_SU, 4, 0, 0);
      send_cmd(KIND_ALIGN, 0, 0, 0);
      send_cmd(KIND_NS, 0, 32'hffff_ffff, 0);
      send_cmd(KIND_RESTART, 0, 0, 0);
      send_cmd(KIND_FBITS, 32, 0, 0);
      send_cmd(KIND_SU, 32, 0, 0);
      send_cmd(KIND_NS, 0, 0, 0);
      send_cmd(KIND_NS, 0, 1, 0);
      send_cmd(KIND_NS, 0, 5, 0);
      send_cmd(KIND_SKIP, 0, 0, 1);
      send_cmd(KIND_ALIGN, 0, 0, 0);
      send_cmd(KIND_TRAIL, 0, 0, 0);
      send_cmd(KIND_RESTART, 0, 0, 0);
      send_cmd(KIND_SKIP, 0, 0, 55);
      send_cmd(KIND_TRAIL, 0, 0, 0);
      send_cmd(KIND_FBITS, 63, 0, 0);
      send_cmd(KIND_FBITS, 1, 0, 0);
      send_cmd(4'd9, 0, 0, 0);
      send_cmd(4'd15, 0, 0, 0);
      send_cmd(KIND_RESTART, 0, 0, 0);
      send_cmd(KIND_SKIP, 0, 0, 16'hffff);
      load_byte(4095, 8'hFF);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin off = 0; size = 0; end
            1: begin off = 4095; size = 4096; end
            2: begin off = 4090; size = 4096; end
            3: begin off = 0; size = 1; end
            default: begin
               off = $urandom_range(0, STORE_BYTES_DEF - 1);
               size = $urandom_range(1, 24);
            end
         endcase
         set_window(off, size);
         for (int n = 0; n < 40; n++) begin
            if (p == 10 && n == 5) long_hold = 1'b1;
            // Shrinking the window under the cursor, without reloading.
            if (n == 25 && p % 4 == 0 && cur_size > 0) begin
               drain();
               cur_size = $urandom_range(0, cur_size - 1);
               write_reg(REG_PAYLOAD_SIZE, cur_size);
            end
            random_cmd();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Run covered %0d command transactions over %0d window settings,", sent, PHASES + 1);
      $display("with %0d results checked under bursty input and stalled output.", checked);
      if (failures == 0) $display("PASS av1_header_bit_reader");
      else $display("FAIL av1_header_bit_reader");
      $finish;
   end

endmodule
